/* sv/bclo_pkg.sv */
// ----------------------------------------------------------------------------
// bclo_pkg
// Shared types, constants and helpers for the per-channel Bayer table stage.
// ----------------------------------------------------------------------------
package bclo_pkg;

  localparam int LUT_DEPTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_PATTERN     = 2'd1;
  localparam logic [1:0] REG_BIT_DEPTH   = 2'd2;
  localparam logic [1:0] REG_LUT_ENTRIES = 2'd3;

  // color filter layouts
  localparam logic [1:0] PAT_RGGB = 2'd0;
  localparam logic [1:0] PAT_BGGR = 2'd1;
  localparam logic [1:0] PAT_GRBG = 2'd2;
  localparam logic [1:0] PAT_GBRG = 2'd3;

  // channel codes
  localparam logic [1:0] CH_R  = 2'd0;
  localparam logic [1:0] CH_GR = 2'd1;
  localparam logic [1:0] CH_GB = 2'd2;
  localparam logic [1:0] CH_B  = 2'd3;

  localparam int BIT_DEPTH_RST   = 12;
  localparam int LUT_ENTRIES_RST = 4096;

  typedef logic [1:0] chan_t;

  // channel from layout and position parity {row_odd, col_odd}
  function automatic chan_t chan_map(input logic [1:0] pattern, input logic [1:0] parity);
    chan_t ch;
    ch = CH_R;
    case (pattern)
      PAT_RGGB: begin
        case (parity)
          2'b00:   ch = CH_R;
          2'b01:   ch = CH_GR;
          2'b10:   ch = CH_GB;
          default: ch = CH_B;
        endcase
      end
      PAT_BGGR: begin
        case (parity)
          2'b00:   ch = CH_B;
          2'b01:   ch = CH_GB;
          2'b10:   ch = CH_GR;
          default: ch = CH_R;
        endcase
      end
      PAT_GRBG: begin
        case (parity)
          2'b00:   ch = CH_GR;
          2'b01:   ch = CH_R;
          2'b10:   ch = CH_B;
          default: ch = CH_GB;
        endcase
      end
      default: begin
        case (parity)
          2'b00:   ch = CH_GB;
          2'b01:   ch = CH_B;
          2'b10:   ch = CH_R;
          default: ch = CH_GR;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

/* sv/bclo_ram.sv */
// ----------------------------------------------------------------------------
// bclo_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bclo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/bayer_channel_lut_oecf.sv */
// Pipeline: an accepted pixel passes the table read with stage A, then the
//   output register, before it is presented.
// Throughput: one transaction per cycle, pixel or table write; an output
//   stall backs up into the input.
// Reset (rst_n low, synchronous): clears valids, parity and config registers
//   to enable 0, layout rggb, bit depth 12, 4096 entries; table RAM undefined.
// ----------------------------------------------------------------------------
// bayer_channel_lut_oecf
// Per-channel Bayer look-up table stage: tracks row/column parity, picks the
// r/gr/gb/b table for each pixel and, when enabled, replaces the pixel by its
// entry inside the table length and clips it to the configured sensor depth.
// ----------------------------------------------------------------------------
module bayer_channel_lut_oecf #(
  parameter int LUT_DEPTH  = bclo_pkg::LUT_DEPTH_DEF,
  parameter int PIXEL_BITS = bclo_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] pixel_in, [17:16] lut_channel, [29:18] lut_addr, [45:30] lut_data
  input  logic [47:0] in_tdata,
  // [0] req_type, [1] start_of_frame
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,   // end_of_line
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] pixel_out
  // [0] looked_up, [2:1] color_channel
  output logic [2:0]  out_tuser
);

  import bclo_pkg::*;

  // Table index width; each channel gets a power-of-two slice of the RAM.
  localparam int AW        = (LUT_DEPTH > 1) ? $clog2(LUT_DEPTH) : 1;
  localparam int RAM_DEPTH = 4 * (2 ** AW);
  localparam logic [31:0] DEPTH32  = 32'(LUT_DEPTH);
  localparam logic [15:0] PIX_MASK = 16'((33'd1 << PIXEL_BITS) - 33'd1);
  localparam logic [4:0]  PBITS5   = 5'(PIXEL_BITS);

  // ---------------------------------------------------------------- config
  logic        enable_r;
  logic [1:0]  pattern_r;
  logic [4:0]  bit_depth_r;
  logic [12:0] lut_entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      pattern_r     <= PAT_RGGB;
      bit_depth_r   <= 5'(BIT_DEPTH_RST);
      lut_entries_r <= 13'(LUT_ENTRIES_RST);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ENABLE:      enable_r      <= cfg_wr_data[0];
        REG_PATTERN:     pattern_r     <= cfg_wr_data[1:0];
        REG_BIT_DEPTH:   bit_depth_r   <= cfg_wr_data[4:0];
        REG_LUT_ENTRIES: lut_entries_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Saturated table length, clip limit. User keeps them static as pixels flow.
  logic [31:0] entries32;
  logic [4:0]  clip_bits;
  logic [16:0] lim17;
  logic [15:0] clip_lim;

  always_comb begin
    entries32 = (32'(lut_entries_r) > DEPTH32) ? DEPTH32 : 32'(lut_entries_r);
    clip_bits = (bit_depth_r > PBITS5) ? PBITS5 : bit_depth_r;
    lim17     = (17'd1 << clip_bits) - 17'd1;
    clip_lim  = lim17[15:0];
  end

  // ---------------------------------------------------------- input unpack
  logic        req_type, sof, eol;
  logic [15:0] pixel_in, lut_data;
  logic [1:0]  lut_channel;
  logic [11:0] lut_addr;

  assign pixel_in    = in_tdata[15:0];
  assign lut_channel = in_tdata[17:16];
  assign lut_addr    = in_tdata[29:18];
  assign lut_data    = in_tdata[45:30];
  assign req_type    = in_tuser[0];
  assign sof         = in_tuser[1];
  assign eol         = in_tlast;

  // --------------------------------------------------------- pipeline ctrl
  // Stage A holds a pixel whose table read is in flight; the output register
  // holds the result while the downstream side stalls.
  logic a_valid_r, a_valid_nxt;
  logic a_hit_r, a_en_r;
  chan_t a_ch_r;
  logic [15:0] a_pix_r;

  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_pix_r;
  logic out_hit_r;
  chan_t out_ch_r;

  logic advance_a, in_acc, pix_acc, wr_acc;

  assign advance_a = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || advance_a;
  assign in_acc    = in_tvalid && in_tready;
  assign pix_acc   = in_acc && !req_type;
  assign wr_acc    = in_acc && req_type;

  // ---------------------------------------------------------- position
  logic row_odd_r, col_odd_r, row_odd_nxt, col_odd_nxt;
  logic row_cur, col_cur;
  chan_t ch_cur;

  always_comb begin
    row_cur     = sof ? 1'b0 : row_odd_r;
    col_cur     = sof ? 1'b0 : col_odd_r;
    ch_cur      = chan_map(pattern_r, {row_cur, col_cur});
    row_odd_nxt = row_odd_r;
    col_odd_nxt = col_odd_r;
    if (pix_acc) begin
      // end of line: next row, column back to even; else step the column
      row_odd_nxt = eol ? ~row_cur : row_cur;
      col_odd_nxt = eol ? 1'b0 : ~col_cur;
    end
  end

  // ---------------------------------------------------------- table access
  logic [15:0] pix_m;
  logic [31:0] pix32, waddr32;
  logic        hit_cur;
  logic        ram_we;
  logic [AW+1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_rdata;

  always_comb begin
    pix_m     = pixel_in & PIX_MASK;
    pix32     = 32'(pix_m);
    waddr32   = 32'(lut_addr);
    hit_cur   = enable_r && (pix32 < entries32);
    // drop writes beyond the table
    ram_we    = wr_acc && (waddr32 < DEPTH32);
    ram_waddr = {lut_channel, waddr32[AW-1:0]};
    ram_raddr = {ch_cur, pix32[AW-1:0]};
  end

  bclo_ram #(
    .WIDTH (16),
    .DEPTH (RAM_DEPTH)
  ) u_tables (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (lut_data),
    .rd_en   (pix_acc),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // ------------------------------------------------------------ stage A
  always_comb begin
    a_valid_nxt = a_valid_r;
    if (pix_acc) begin
      a_valid_nxt = 1'b1;
    end else if (advance_a) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      row_odd_r <= 1'b0;
      col_odd_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      row_odd_r <= row_odd_nxt;
      col_odd_r <= col_odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      a_hit_r <= hit_cur;
      a_en_r  <= enable_r;
      a_ch_r  <= ch_cur;
      a_pix_r <= pix_m;
    end
  end

  // --------------------------------------------------------- result stage
  // RAM data holds while stage A is stalled: no new read without acceptance.
  logic [15:0] res_sel, res_clip;

  always_comb begin
    res_sel  = a_hit_r ? ram_rdata : a_pix_r;
    res_clip = (a_en_r && (res_sel > clip_lim)) ? clip_lim : res_sel;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance_a) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_a) begin
      out_pix_r <= res_clip;
      out_hit_r <= a_hit_r;
      out_ch_r  <= a_ch_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = {out_ch_r, out_hit_r};

endmodule

/* bench/bayer_channel_lut_oecf_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bayer_channel_lut_oecf_tb
// Self-checking bench for the per-channel Bayer table stage. Random frames,
// broken rows and table writes are pushed into the block in bursts while the
// result side stalls on its own schedule. A scoreboard tracks pixel position,
// table contents and settings, and compares every result field by field.
// ----------------------------------------------------------------------------
module bayer_channel_lut_oecf_tb;
  import bclo_pkg::*;

  localparam int DEPTH          = LUT_DEPTH_DEF;
  localparam int RESULT_LATENCY = 2;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 60;

  // one input transaction, unpacked
  typedef struct {
    bit        req;   // 0 pixel, 1 table write
    bit [15:0] pix;
    bit        sof;
    bit        eol;
    chan_t     wch;
    bit [11:0] wadr;
    bit [15:0] wdat;
  } lut_req_t;

  // one predicted result
  typedef struct {
    bit [15:0] pix;
    bit        hit;
    chan_t     ch;
  } oecf_res_t;

  // Keeps its own copy of settings, position and tables; holds the results
  // still owed by the block in arrival order.
  class oecf_scoreboard;
    bit        enable;
    bit [1:0]  pattern;
    bit [4:0]  depth;
    bit [12:0] entries;
    bit        row_odd;
    bit        col_odd;
    chan_t     layout [4][4];
    bit [15:0] tbl [4][DEPTH];
    bit        loaded [4][DEPTH];
    oecf_res_t owed [$];
    int        errors;

    function new();
      enable  = 1'b0;
      pattern = PAT_RGGB;
      depth   = 5'(BIT_DEPTH_RST);
      entries = 13'(LUT_ENTRIES_RST);
      row_odd = 1'b0;
      col_odd = 1'b0;
      errors  = 0;
      // channel by layout, indexed by {row_odd, col_odd}
      layout[PAT_RGGB] = '{CH_R, CH_GR, CH_GB, CH_B};
      layout[PAT_BGGR] = '{CH_B, CH_GB, CH_GR, CH_R};
      layout[PAT_GRBG] = '{CH_GR, CH_R, CH_B, CH_GB};
      layout[PAT_GBRG] = '{CH_GB, CH_B, CH_R, CH_GR};
    endfunction

    function void set_reg(bit [1:0] idx, bit [12:0] val);
      case (idx)
        REG_ENABLE:      enable  = val[0];
        REG_PATTERN:     pattern = val[1:0];
        REG_BIT_DEPTH:   depth   = val[4:0];
        REG_LUT_ENTRIES: entries = val;
        default: ;
      endcase
    endfunction

    function int unsigned table_len();
      return (entries > DEPTH) ? DEPTH : entries;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // channel the next pixel will land on, and whether it would read an
    // entry that has never been loaded
    function bit needs_load(bit [15:0] pix, bit sof, output chan_t ch);
      bit [1:0] par;
      par = sof ? 2'b00 : {row_odd, col_odd};
      ch  = layout[pattern][par];
      return enable && (pix < table_len()) && !loaded[ch][pix[11:0]];
    endfunction

    function void note_input(lut_req_t r);
      oecf_res_t res;
      bit [16:0] lim;
      if (r.req) begin
        tbl[r.wch][r.wadr]    = r.wdat;
        loaded[r.wch][r.wadr] = 1'b1;
        return;
      end
      if (r.sof) begin
        row_odd = 1'b0;
        col_odd = 1'b0;
      end
      res.ch  = layout[pattern][{row_odd, col_odd}];
      res.pix = r.pix;
      res.hit = 1'b0;
      if (enable) begin
        if (r.pix < table_len()) begin
          res.pix = tbl[res.ch][r.pix[11:0]];
          res.hit = 1'b1;
        end
        lim = (depth > 5'd16) ? 17'h0FFFF : (17'd1 << depth) - 17'd1;
        if (res.pix > lim) res.pix = lim[15:0];
      end
      owed.push_back(res);
      if (r.eol) begin
        row_odd = ~row_odd;
        col_odd = 1'b0;
      end else begin
        col_odd = ~col_odd;
      end
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 10)
        $display("[%0t] %s mismatch: expected 'h%0h, got 'h%0h", $time, what, want, got);
    endfunction

    function void check_result(logic [15:0] pix, logic hit, logic [1:0] ch);
      oecf_res_t want;
      if (owed.size() == 0) begin
        report("unrequested result", 0, pix);
        return;
      end
      want = owed.pop_front();
      if (pix !== want.pix) report("pixel_out", want.pix, pix);
      if (hit !== want.hit) report("looked_up", want.hit, hit);
      if (ch !== want.ch)   report("color_channel", want.ch, ch);
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_addr    = '0;
  logic [12:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = '0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  oecf_scoreboard sb;
  int burst_left = 6;
  int sent       = 0;
  int cyc        = 0;

  always #5 clk = ~clk;

  bayer_channel_lut_oecf i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),   // [15:0] pixel_in, [17:16] lut_channel, [29:18] lut_addr,
                               // [45:30] lut_data
    .in_tuser    (in_tuser),   // [0] req_type, [1] start_of_frame
    .in_tlast    (in_tlast),   // end_of_line
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),  // [15:0] pixel_out
    .out_tuser   (out_tuser)   // [0] looked_up, [2:1] color_channel
  );

  // Result side: cycle through four stall schemes in turn: always ready,
  // mostly ready, mostly stalled, and a fixed pattern taken from the cycle
  // count. Also watch the cycle budget.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc / 97) % 4)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((cyc % 7) < 3);
    endcase
    if (cyc >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every result transaction against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser[0], out_tuser[2:1]);
  end

  // Drop valid and hold it low for the given span (n >= 1).
  task automatic hold_off(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drive one transaction, hold it until accepted, then log it. Bursts end in
  // random gaps, now and then long ones.
  task automatic send_item(lut_req_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, r.wdat, r.wadr, r.wch, r.pix};
    in_tuser  <= {r.sof, r.req};
    in_tlast  <= r.eol;
    do @(posedge clk); while (!in_tready);
    sb.note_input(r);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      hold_off(($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
    end
  endtask

  function automatic bit [15:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Fill every field with noise; callers override the ones that matter.
  function automatic lut_req_t noise_fields();
    lut_req_t r;
    r.req  = 1'($urandom_range(0, 1));
    r.pix  = rand_word();
    r.sof  = 1'($urandom_range(0, 1));
    r.eol  = 1'($urandom_range(0, 1));
    r.wch  = chan_t'($urandom_range(0, 3));
    r.wadr = 12'($urandom_range(0, 4095));
    r.wdat = rand_word();
    return r;
  endfunction

  // Bias pixels toward lookups, the table length boundary and the extremes.
  function automatic bit [15:0] rand_pixel();
    int unsigned len;
    int unsigned v;
    len = sb.table_len();
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 31);
      1: begin
        v = len + $urandom_range(0, 3);
        v = (v >= 2) ? v - 2 : 0;
        if (v > 65535) v = 65535;
      end
      2, 3: v = $urandom_range(0, 65535);
      4: v = (len > 0) ? $urandom_range(0, len - 1) : 0;
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h0000;
          1:       v = 16'hFFFF;
          2:       v = 16'h8000;
          default: v = 16'h0FFF;
        endcase
      end
    endcase
    return v[15:0];
  endfunction

  task automatic send_write(chan_t ch, bit [11:0] adr, bit [15:0] dat);
    lut_req_t r;
    r      = noise_fields();
    r.req  = 1'b1;
    r.wch  = ch;
    r.wadr = adr;
    r.wdat = dat;
    send_item(r);
  endtask

  // Send a pixel; load its table entry first if the lookup would otherwise
  // land on an entry never written.
  task automatic send_pixel(bit [15:0] pix, bit sof, bit eol);
    lut_req_t r;
    chan_t    ch;
    r = noise_fields();
    if (sb.needs_load(pix, sof, ch)) send_write(ch, pix[11:0], rand_word());
    r.req = 1'b0;
    r.pix = pix;
    r.sof = sof;
    r.eol = eol;
    send_item(r);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [12:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(bit en, bit [1:0] pat, bit [4:0] bd, bit [12:0] ent);
    write_reg(REG_ENABLE, 13'(en));
    write_reg(REG_PATTERN, 13'(pat));
    write_reg(REG_BIT_DEPTH, 13'(bd));
    write_reg(REG_LUT_ENTRIES, ent);
    cfg_wr_en <= 1'b0;
  endtask

  // Stop sending, wait for every owed result, then linger so a trailing
  // table write has settled too.
  task automatic drain_results(int linger);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (linger) @(posedge clk);
  endtask

  // Well-formed frame: start-of-frame on the first pixel, end-of-line closing
  // each row, occasional table writes slipped between pixels.
  task automatic run_frame();
    int w;
    int h;
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 4);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if ($urandom_range(0, 9) == 0)
          send_write(chan_t'($urandom_range(0, 3)), 12'($urandom_range(0, 31)), rand_word());
        send_pixel(rand_pixel(), (x == 0) && (y == 0), x == w - 1);
      end
    end
  endtask

  // Broken sequences: stray flags, writes mixed in at random.
  task automatic run_noise();
    int n;
    n = $urandom_range(4, 12);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        send_write(chan_t'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)), rand_word());
      else
        send_pixel(rand_pixel(), $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    bit [4:0]  depth_pick [PHASES];
    bit [12:0] len_pick [PHASES];
    int        goal;
    bit        paused;

    depth_pick = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd12, 5'd17, 5'd8, 5'd5};
    len_pick   = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd4097, 13'd64, 13'd4095, 13'd300};
    paused     = 1'b0;
    sb         = new();

    // hold reset at the start, never again
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: disabled, so pixels pass unclipped while parity moves.
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'h0000, 1'b0, 1'b1);
    send_pixel(16'h1234, 1'b0, 1'b0);
    drain_results(RESULT_LATENCY + 2);

    // Full depth: table extremes on every channel, then pixels at and past
    // the table length.
    configure(1'b1, PAT_RGGB, 5'd16, 13'd4096);
    send_write(CH_R, 12'h000, 16'hFFFF);
    send_write(CH_GR, 12'hFFF, 16'h0000);
    send_write(CH_GB, 12'h000, 16'h8000);
    send_write(CH_B, 12'hFFF, 16'hFFFF);
    send_pixel(16'h0000, 1'b1, 1'b0);
    send_pixel(16'h0FFF, 1'b0, 1'b1);
    send_pixel(16'h0000, 1'b0, 1'b0);
    send_pixel(16'h0FFF, 1'b0, 1'b1);
    send_pixel(16'h1000, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    drain_results(RESULT_LATENCY + 2);

    // Zero depth clips everything to 0; zero entries means no lookup.
    configure(1'b1, PAT_BGGR, 5'd0, 13'd0);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'h0000, 1'b0, 1'b1);
    drain_results(RESULT_LATENCY + 2);

    // Depth past the pixel width and entries past the table size saturate.
    configure(1'b1, PAT_GRBG, 5'd31, 13'd8191);
    send_pixel(16'h0FFF, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    drain_results(RESULT_LATENCY + 2);

    // One-bit depth with a single entry.
    configure(1'b1, PAT_GBRG, 5'd1, 13'd1);
    send_pixel(16'h0000, 1'b1, 1'b1);
    send_pixel(16'h0001, 1'b0, 1'b0);
    drain_results(RESULT_LATENCY + 2);

    // Random phases, each under its own settings; every fourth starts
    // disabled.
    for (int ph = 0; ph < PHASES; ph++) begin
      configure(ph % 4 != 1, 2'(ph % 4), depth_pick[ph], len_pick[ph]);
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: run_frame();
          7, 8:                run_noise();
          default: begin
            repeat ($urandom_range(1, 8))
              send_write(chan_t'($urandom_range(0, 3)),
                         ($urandom_range(0, 4) < 2) ? 12'($urandom_range(0, 31))
                                                    : 12'($urandom_range(0, 4095)),
                         rand_word());
          end
        endcase
        // once, mid-phase: let the block run empty before carrying on
        if (ph == 3 && !paused && sent > goal - PHASE_ITEMS / 2) begin
          drain_results(1);
          paused = 1'b1;
        end
      end
      drain_results(RESULT_LATENCY + 2);
    end

    drain_results(RESULT_LATENCY + 4);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
